@@ rtl/cpc_pkg.sv @@
// ----------------------------------------------------------------------------
// cpc_pkg: shared types and constants for the cartesian/polar converter
// Holds the pipeline word, the arctangent table and the gain helper.
// ----------------------------------------------------------------------------
`default_nettype none

package cpc_pkg;

    // datapath widths: x, y carry the input scaled by 2^14 plus CORDIC growth
    localparam int XY_W    = 34;
    localparam int Z_W     = 33;
    localparam int FRAC_SH = 14;

    localparam logic [Z_W-1:0] Z_PI = 33'h0_8000_0000;

    // one item travelling down the CORDIC pipe
    typedef struct packed {
        logic                   vld;
        logic                   mode;   // 0 vectoring, 1 rotation
        logic                   zero;   // vectoring input was (0,0)
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic        [Z_W-1:0]  z;      // binary angle, 2^32 per turn
    } t_cordic;

    // round(atan(2^-i) * 2^32 / (2*pi))
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // floor(sqrt(prod(1 + 2^-2i))) in Q30, evaluated at elaboration
    function automatic logic [63:0] gain_root(input int iters);
        logic [63:0] p;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        logic [5:0]  sh;
        p = 64'd1 << 60;
        for (int i = 0; i < iters; i++) begin
            sh = 6'(2 * (i & 31));
            p  = p + (p >> sh);
        end
        v    = p;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) begin
            bitv = bitv >> 2;
        end
        while (bitv != 64'd0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cartesian_polar_conversion.sv @@
// ----------------------------------------------------------------------------
// cartesian_polar_conversion: pipelined CORDIC vector converter
// Cartesian to polar (magnitude, atan2) or polar to cartesian per request.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the output side keeps up and
// returns one result per request, in order, through one input register, one
// register per CORDIC micro-rotation, one register after the gain multipliers
// and the output register. Each stage holds its item while the next one is
// full, so a stall at the output backs up only as far as the pipe is full;
// bubbles are squeezed out. Angles are binary angles, 65536 counts per turn.
// The CORDIC gain is divided out.
`default_nettype none

module cartesian_polar_conversion #(
    parameter int ITERATIONS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // in_x [15:0], in_y [31:16], in_mag [46:32], in_angle [62:47], zero [63]
    input  wire logic [63:0] i_s_axis_tdata,
    // cmd [0]
    input  wire logic [0:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // out_x [15:0], out_y [31:16], out_mag [47:32], out_angle [63:48]
    output logic [63:0]      o_m_axis_tdata,
    // out_mode [0]
    output logic [0:0]       o_m_axis_tuser
);
    import cpc_pkg::*;

    t_cordic     s_item  [ITERATIONS+1];
    logic        s_ready [ITERATIONS+1];
    logic        out_mode;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [15:0] out_mag;
    logic [15:0] out_angle;

    cpc_pre u_pre (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_cmd      (i_s_axis_tuser[0]),
        .i_in_x     (i_s_axis_tdata[15:0]),
        .i_in_y     (i_s_axis_tdata[31:16]),
        .i_in_mag   (i_s_axis_tdata[46:32]),
        .i_in_angle (i_s_axis_tdata[62:47]),
        .o_item     (s_item[0]),
        .i_ready    (s_ready[0])
    );

    for (genvar k = 0; k < ITERATIONS; k++) begin : g_stage
        cpc_stage #(
            .SHIFT (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_item  (s_item[k]),
            .o_ready (s_ready[k]),
            .o_item  (s_item[k+1]),
            .i_ready (s_ready[k+1])
        );
    end

    cpc_scale #(
        .ITERATIONS (ITERATIONS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (s_item[ITERATIONS]),
        .o_ready (s_ready[ITERATIONS]),
        .o_valid (o_m_axis_tvalid),
        .o_mode  (out_mode),
        .o_x     (out_x),
        .o_y     (out_y),
        .o_mag   (out_mag),
        .o_angle (out_angle),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {out_angle, out_mag, out_y, out_x};
    assign o_m_axis_tuser = out_mode;

endmodule

`default_nettype wire

@@ rtl/cpc_pre.sv @@
// ----------------------------------------------------------------------------
// cpc_pre: input stage
// Unpacks a request, folds it into the right half-plane and scales to Q14.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_pre (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic             i_cmd,
    input  wire logic [15:0]      i_in_x,
    input  wire logic [15:0]      i_in_y,
    input  wire logic [14:0]      i_in_mag,
    input  wire logic [15:0]      i_in_angle,
    output cpc_pkg::t_cordic      o_item,
    input  wire logic             i_ready
);
    import cpc_pkg::*;

    localparam logic signed [16:0] QUARTER = 17'sh04000;
    localparam logic signed [16:0] HALF    = 17'sh08000;

    t_cordic r_item;
    t_cordic n_item;

    logic signed [XY_W-1:0] sx;
    logic signed [XY_W-1:0] sy;
    logic signed [XY_W-1:0] smag;
    logic signed [16:0]     ang;
    logic signed [16:0]     ang_adj;

    always_comb begin
        sx      = XY_W'($signed(i_in_x));
        sy      = XY_W'($signed(i_in_y));
        smag    = XY_W'({1'b0, i_in_mag});
        ang     = {i_in_angle[15], i_in_angle};
        ang_adj = ang;
        n_item      = '0;
        n_item.vld  = i_valid;
        n_item.mode = i_cmd;
        if (!i_cmd) begin
            n_item.zero = (i_in_x == 16'd0) && (i_in_y == 16'd0);
            if (sx < 0) begin
                n_item.x = (-sx) <<< FRAC_SH;
                n_item.y = (-sy) <<< FRAC_SH;
                n_item.z = Z_PI;
            end else begin
                n_item.x = sx <<< FRAC_SH;
                n_item.y = sy <<< FRAC_SH;
                n_item.z = '0;
            end
        end else begin
            // beyond +-pi/2: start from -mag and shift the angle by pi
            n_item.x = smag <<< FRAC_SH;
            if (ang > QUARTER) begin
                n_item.x = -(smag <<< FRAC_SH);
                ang_adj  = ang - HALF;
            end else if (ang < -QUARTER) begin
                n_item.x = -(smag <<< FRAC_SH);
                ang_adj  = ang + HALF;
            end
            n_item.y = '0;
            n_item.z = {ang_adj, 16'h0000};
        end
    end

    assign o_ready = !r_item.vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else if (o_ready) begin
            r_item.vld <= n_item.vld;
        end
        if (o_ready) begin
            r_item.mode <= n_item.mode;
            r_item.zero <= n_item.zero;
            r_item.x    <= n_item.x;
            r_item.y    <= n_item.y;
            r_item.z    <= n_item.z;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

@@ rtl/cpc_stage.sv @@
// ----------------------------------------------------------------------------
// cpc_stage: one CORDIC micro-rotation
// Shift-add step with a fixed shift, vectoring or rotation by item mode.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_stage #(
    parameter int SHIFT = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire cpc_pkg::t_cordic i_item,
    output logic                  o_ready,
    output cpc_pkg::t_cordic      o_item,
    input  wire logic             i_ready
);
    import cpc_pkg::*;

    localparam logic [4:0]     TAB_IDX = 5'(SHIFT);
    localparam logic [Z_W-1:0] ANG     = {1'b0, ATAN_TAB[TAB_IDX]};

    t_cordic r_item;
    t_cordic n_item;

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic                   up;

    always_comb begin
        xs = i_item.x >>> TAB_IDX;
        ys = i_item.y >>> TAB_IDX;
        // vectoring drives y toward zero, rotation drives z toward zero
        up = i_item.mode ? !i_item.z[Z_W-1] : (i_item.y > 0);
        if (i_item.mode) begin
            up = !i_item.z[Z_W-1];
        end
        n_item = i_item;
        if (i_item.mode ^ up) begin
            n_item.x = i_item.x + ys;
            n_item.y = i_item.y - xs;
        end else begin
            n_item.x = i_item.x - ys;
            n_item.y = i_item.y + xs;
        end
        if (up) begin
            n_item.z = i_item.z + (i_item.mode ? -ANG : ANG);
        end else begin
            n_item.z = i_item.z - (i_item.mode ? -ANG : ANG);
        end
    end

    assign o_ready = !r_item.vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else if (o_ready) begin
            r_item.vld <= n_item.vld;
        end
        if (o_ready) begin
            r_item.mode <= n_item.mode;
            r_item.zero <= n_item.zero;
            r_item.x    <= n_item.x;
            r_item.y    <= n_item.y;
            r_item.z    <= n_item.z;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

@@ rtl/cpc_scale.sv @@
// ----------------------------------------------------------------------------
// cpc_scale: gain compensation and output register
// Multiplies by 1/K, rounds half up, saturates and forms the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_scale #(
    parameter int ITERATIONS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire cpc_pkg::t_cordic i_item,
    output logic                  o_ready,
    output logic                  o_valid,
    output logic                  o_mode,
    output logic [15:0]           o_x,
    output logic [15:0]           o_y,
    output logic [15:0]           o_mag,
    output logic [15:0]           o_angle,
    input  wire logic             i_ready
);
    import cpc_pkg::*;

    localparam logic [63:0] GAIN_ROOT = gain_root(ITERATIONS);
    localparam logic [63:0] GAIN_FULL = (64'd1 << 61) / GAIN_ROOT;
    localparam logic [31:0] GAIN_K    = GAIN_FULL[31:0];
    localparam logic signed [63:0] RND = 64'sh0000_1000_0000_0000;

    // multiply stage
    logic               r1_valid;
    logic               r1_mode;
    logic               r1_zero;
    logic signed [63:0] r1_px;
    logic signed [63:0] r1_py;
    logic [15:0]        r1_angle;

    logic signed [31:0] x32;
    logic signed [31:0] y32;
    logic signed [32:0] k33;
    logic signed [63:0] n1_px;
    logic signed [63:0] n1_py;
    logic [31:0]        z_rnd;
    logic               ready1;
    logic               ready2;

    // output stage
    logic               r2_valid;
    logic               r2_mode;
    logic [15:0]        r2_x;
    logic [15:0]        r2_y;
    logic [15:0]        r2_mag;
    logic [15:0]        r2_angle;

    logic [15:0]        n2_x;
    logic [15:0]        n2_y;
    logic [15:0]        n2_mag;
    logic [15:0]        n2_angle;
    logic signed [63:0] sum_x;
    logic signed [63:0] sum_y;
    logic signed [18:0] vx;
    logic signed [18:0] vy;

    function automatic logic [15:0] sat16(input logic signed [18:0] v);
        logic [15:0] res;
        if (v > 19'sd32767) begin
            res = 16'h7FFF;
        end else if (v < -19'sd32768) begin
            res = 16'h8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    always_comb begin
        x32   = i_item.x[31:0];
        y32   = i_item.y[31:0];
        k33   = {1'b0, GAIN_K};
        n1_px = x32 * k33;
        n1_py = y32 * k33;
        z_rnd = i_item.z[31:0] + 32'h0000_8000;
    end

    assign ready2  = !r2_valid || i_ready;
    assign ready1  = !r1_valid || ready2;
    assign o_ready = ready1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (ready1) begin
            r1_valid <= i_item.vld;
        end
        if (ready1) begin
            r1_mode  <= i_item.mode;
            r1_zero  <= i_item.zero;
            r1_px    <= n1_px;
            r1_py    <= n1_py;
            r1_angle <= z_rnd[31:16];
        end
    end

    always_comb begin
        sum_x    = r1_px + RND;
        sum_y    = r1_py + RND;
        vx       = sum_x[63:45];
        vy       = sum_y[63:45];
        n2_x     = '0;
        n2_y     = '0;
        n2_mag   = '0;
        n2_angle = '0;
        if (r1_mode) begin
            n2_x = sat16(vx);
            n2_y = sat16(vy);
        end else if (!r1_zero) begin
            if (vx < 0) begin
                n2_mag = '0;
            end else if (vx > 19'sd65535) begin
                n2_mag = 16'hFFFF;
            end else begin
                n2_mag = vx[15:0];
            end
            n2_angle = r1_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (ready2) begin
            r2_valid <= r1_valid;
        end
        if (ready2) begin
            r2_mode  <= r1_mode;
            r2_x     <= n2_x;
            r2_y     <= n2_y;
            r2_mag   <= n2_mag;
            r2_angle <= n2_angle;
        end
    end

    assign o_valid = r2_valid;
    assign o_mode  = r2_mode;
    assign o_x     = r2_x;
    assign o_y     = r2_y;
    assign o_mag   = r2_mag;
    assign o_angle = r2_angle;

endmodule

`default_nettype wire

@@ rtl/cpc_checker.sv @@
// ----------------------------------------------------------------------------
// cpc_checker: port-level checks for the converter
// Reset, stall and result-field rules seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_s_axis_tready,
    input  wire logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [63:0] o_m_axis_tdata,
    input  wire logic [0:0]  o_m_axis_tuser
);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // input backpressure only when every stage is full and the output waits
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("request refused with room in the pipe");

    // unused fields of each mode read as zero
    a_polar_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[31:0] == 32'd0)
        else $error("cartesian fields set in polar result");

    a_cart_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata[63:32] == 32'd0)
        else $error("polar fields set in cartesian result");

endmodule

bind cartesian_polar_conversion cpc_checker u_cpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: regression for cartesian_polar_conversion
// Streams vectoring and rotation requests through the CORDIC converter,
// predicts every untyped result with a bit-exact fixed-point CORDIC of its
// own and compares the output stream field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CORDIC_STEPS = 16;
    localparam int RAND_ITEMS   = 850;
    localparam int QUIET_ITEMS  = 150;  // tail of the run with no idling
    localparam int HOLD_CYCLES  = 100;  // long output stall, fills the pipe
    localparam int DRAIN_CYCLES = 2 * (CORDIC_STEPS + 3);

    localparam logic MODE_TO_POLAR = 1'b0;
    localparam logic MODE_TO_CART  = 1'b1;

    // round(atan(2^-i) * 2^32 / (2*pi))
    localparam logic [31:0] ARCTAN_STEP [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct {
        logic               mode;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic        [15:0] mag;
        logic signed [15:0] angle;
    } t_conv_res;

    typedef struct {
        logic               cmd;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic        [14:0] mag;
        logic signed [15:0] angle;
        bit                 typed;   // expected result is all zeros
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // in_x [15:0], in_y [31:16], in_mag [46:32], in_angle [62:47], zero [63]
    logic [63:0] i_s_axis_tdata = '0;
    // cmd [0]
    logic [0:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // out_x [15:0], out_y [31:16], out_mag [47:32], out_angle [63:48]
    logic [63:0] o_m_axis_tdata;
    // out_mode [0]
    logic [0:0]  o_m_axis_tuser;

    t_conv_res   due_results [$];
    t_stim_row   directed_rows [$];
    longint      gain_k;
    int          mismatch_cnt = 0;
    int          result_cnt = 0;
    bit          quiet_tail = 1'b0;
    bit          sink_hold_req = 1'b0;
    t_conv_res   got_res;
    t_conv_res   want_res;

    cartesian_polar_conversion #(
        .ITERATIONS (CORDIC_STEPS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Q31 reciprocal of the CORDIC gain
    function automatic longint calc_gain_k();
        longint unsigned p;
        longint unsigned rem;
        longint unsigned root;
        longint unsigned b;
        p = 64'd1 << 60;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            p += p >> ((2 * (i % 32)) % 64);
        end
        // digit-by-digit integer square root, Q60 -> Q30
        rem  = p;
        root = 0;
        b    = 64'd1 << 62;
        while (b > rem) begin
            b >>= 2;
        end
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return longint'((64'd1 << 61) / root);
    endfunction

    function automatic longint gain_scale(input longint v);
        return (v * gain_k + (longint'(1) << 44)) >>> 45;
    endfunction

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end else if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic t_conv_res blank_result(input logic cmd);
        t_conv_res r;
        r.mode  = cmd;
        r.x     = '0;
        r.y     = '0;
        r.mag   = '0;
        r.angle = '0;
        return r;
    endfunction

    function automatic t_conv_res convert_vector(input logic cmd,
                                                 input logic signed [15:0] vx,
                                                 input logic signed [15:0] vy,
                                                 input logic [14:0] vmag,
                                                 input logic signed [15:0] vang);
        t_conv_res   r;
        longint      xa;
        longint      ya;
        longint      za;
        longint      xs;
        longint      ys;
        longint      m;
        logic [31:0] zv;
        logic [31:0] zr;
        int          s;
        r = blank_result(cmd);
        if (cmd == MODE_TO_POLAR) begin
            xa = longint'(vx);
            ya = longint'(vy);
            zv = '0;
            if (xa == 0 && ya == 0) begin
                return r;
            end
            // left half-plane: rotate by pi first
            if (xa < 0) begin
                xa = -xa;
                ya = -ya;
                zv = 32'h8000_0000;
            end
            xa = xa * 16384;
            ya = ya * 16384;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                s  = i % 32;
                xs = xa >>> s;
                ys = ya >>> s;
                if (ya > 0) begin
                    xa = xa + ys;
                    ya = ya - xs;
                    zv = zv + ARCTAN_STEP[s];
                end else begin
                    xa = xa - ys;
                    ya = ya + xs;
                    zv = zv - ARCTAN_STEP[s];
                end
            end
            m = gain_scale(xa);
            if (m < 0) begin
                m = 0;
            end
            if (m > 65535) begin
                m = 65535;
            end
            r.mag   = m[15:0];
            zr      = zv + 32'h0000_8000;
            r.angle = zr[31:16];
        end else begin
            xa = longint'(vmag) * 16384;
            ya = 0;
            za = longint'(vang) * 65536;
            // beyond +-pi/2: start from the opposite vector
            if (za > (longint'(1) << 30)) begin
                xa = -xa;
                za = za - (longint'(1) << 31);
            end else if (za < -(longint'(1) << 30)) begin
                xa = -xa;
                za = za + (longint'(1) << 31);
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                s  = i % 32;
                xs = xa >>> s;
                ys = ya >>> s;
                if (za >= 0) begin
                    xa = xa - ys;
                    ya = ya + xs;
                    za = za - longint'(ARCTAN_STEP[s]);
                end else begin
                    xa = xa + ys;
                    ya = ya - xs;
                    za = za + longint'(ARCTAN_STEP[s]);
                end
            end
            r.x = clip16(gain_scale(xa));
            r.y = clip16(gain_scale(ya));
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 result_cnt, what, got, want);
    endtask

    task automatic add_row(input logic cmd, input logic signed [15:0] vx,
                           input logic signed [15:0] vy, input logic [14:0] vmag,
                           input logic signed [15:0] vang, input bit typed);
        t_stim_row row;
        row.cmd   = cmd;
        row.x     = vx;
        row.y     = vy;
        row.mag   = vmag;
        row.angle = vang;
        row.typed = typed;
        directed_rows.push_back(row);
    endtask

    task automatic send_request(input t_stim_row row);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, row.angle, row.mag, row.y, row.x};
        i_s_axis_tuser  <= row.cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        if (row.typed) begin
            due_results.push_back(blank_result(row.cmd));
        end else begin
            due_results.push_back(convert_vector(row.cmd, row.x, row.y,
                                                 row.mag, row.angle));
        end
    endtask

    // source gap: valid low, junk on the data lines
    task automatic source_idle(input int n);
        i_s_axis_tvalid <= 1'b0;
        repeat (n) begin
            i_s_axis_tdata <= {$urandom, $urandom};
            i_s_axis_tuser <= 1'($urandom_range(0, 1));
            @(posedge i_clk);
        end
    endtask

    // output side ready pattern
    initial begin : sink_ctl
        int n;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (quiet_tail) begin
                i_m_axis_tready <= 1'b1;
                n = 1;
            end else if (sink_hold_req) begin
                i_m_axis_tready <= 1'b0;
                n = HOLD_CYCLES;
                sink_hold_req = 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                i_m_axis_tready <= 1'b0;
                n = $urandom_range(1, 6);
            end else begin
                i_m_axis_tready <= 1'b1;
                n = $urandom_range(1, 12);
            end
            repeat (n) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_res.mode  = o_m_axis_tuser[0];
            got_res.x     = o_m_axis_tdata[15:0];
            got_res.y     = o_m_axis_tdata[31:16];
            got_res.mag   = o_m_axis_tdata[47:32];
            got_res.angle = o_m_axis_tdata[63:48];
            if (due_results.size() == 0) begin
                flag_mismatch("unexpected result, mode", got_res.mode, 0);
            end else begin
                want_res = due_results.pop_front();
                if (got_res.mode !== want_res.mode)
                    flag_mismatch("out_mode", got_res.mode, want_res.mode);
                if (got_res.x !== want_res.x)
                    flag_mismatch("out_x", got_res.x, want_res.x);
                if (got_res.y !== want_res.y)
                    flag_mismatch("out_y", got_res.y, want_res.y);
                if (got_res.mag !== want_res.mag)
                    flag_mismatch("out_mag", got_res.mag, want_res.mag);
                if (got_res.angle !== want_res.angle)
                    flag_mismatch("out_angle", got_res.angle, want_res.angle);
            end
            result_cnt++;
        end
    end

    initial begin : timeout
        #2_000_000;
        $display("cartesian_polar_conversion regression: fail");
        $finish;
    end

    initial begin : stimulus
        t_stim_row row;
        gain_k = calc_gain_k();

        // directed table: zero-result rows are typed, the rest predicted
        add_row(MODE_TO_POLAR, 16'sd0, 16'sd0, 15'h5A5A, 16'sh1234, 1'b1);
        add_row(MODE_TO_POLAR, 16'sh7FFF, 16'sd0, 15'h0, 16'sd0, 1'b0);
        add_row(MODE_TO_POLAR, 16'sh8000, 16'sd0, 15'h7FFF, 16'sh7FFF, 1'b0);
        add_row(MODE_TO_POLAR, 16'sd0, 16'sh7FFF, 15'h0, 16'sd0, 1'b0);
        add_row(MODE_TO_POLAR, 16'sd0, 16'sh8000, 15'h0, 16'sd0, 1'b0);
        add_row(MODE_TO_POLAR, 16'sh8000, 16'sh8000, 15'h0, 16'sd0, 1'b0);
        add_row(MODE_TO_POLAR, 16'sh7FFF, 16'sh7FFF, 15'h0, 16'sd0, 1'b0);
        add_row(MODE_TO_POLAR, 16'sh8000, 16'sh7FFF, 15'h0, 16'sd0, 1'b0);
        add_row(MODE_TO_POLAR, -16'sd1, 16'sd0, 15'h0, 16'sd0, 1'b0);
        add_row(MODE_TO_POLAR, 16'sd0, -16'sd1, 15'h0, 16'sd0, 1'b0);
        add_row(MODE_TO_POLAR, -16'sd1, 16'sd1, 15'h0, 16'sd0, 1'b0);
        add_row(MODE_TO_CART, 16'sh7FFF, 16'sh8000, 15'h0, 16'sd12345, 1'b1);
        add_row(MODE_TO_CART, 16'sd0, 16'sd0, 15'h0, 16'sh8000, 1'b1);
        add_row(MODE_TO_CART, 16'sd0, 16'sd0, 15'h7FFF, 16'sd0, 1'b0);
        add_row(MODE_TO_CART, 16'sd0, 16'sd0, 15'h7FFF, 16'sh8000, 1'b0);
        add_row(MODE_TO_CART, 16'sd0, 16'sd0, 15'h7FFF, 16'sh7FFF, 1'b0);
        add_row(MODE_TO_CART, 16'sd0, 16'sd0, 15'h7FFF, 16'sd16384, 1'b0);
        add_row(MODE_TO_CART, 16'sd0, 16'sd0, 15'h7FFF, 16'sd16385, 1'b0);
        add_row(MODE_TO_CART, 16'sd0, 16'sd0, 15'h7FFF, -16'sd16384, 1'b0);
        add_row(MODE_TO_CART, 16'sd0, 16'sd0, 15'h7FFF, -16'sd16385, 1'b0);
        add_row(MODE_TO_CART, 16'sd0, 16'sd0, 15'h7FFF, 16'sd8192, 1'b0);
        add_row(MODE_TO_CART, 16'sd0, 16'sd0, 15'h1, -16'sd1, 1'b0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i]);
            if ($urandom_range(0, 3) == 0) begin
                source_idle($urandom_range(1, 6));
            end
        end

        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k == 20) begin
                sink_hold_req = 1'b1;
            end
            if (k == RAND_ITEMS - QUIET_ITEMS) begin
                quiet_tail = 1'b1;
            end
            row.cmd   = 1'($urandom_range(0, 1));
            row.x     = 16'($urandom);
            row.y     = 16'($urandom);
            row.mag   = 15'($urandom);
            row.angle = 16'($urandom);
            row.typed = 1'b0;
            case ($urandom_range(0, 7))
                0: begin
                    // tiny vectors, zero included
                    row.x   = 16'($urandom_range(0, 8));
                    row.x   = row.x - 16'sd4;
                    row.y   = 16'($urandom_range(0, 8));
                    row.y   = row.y - 16'sd4;
                    row.mag = 15'($urandom_range(0, 3));
                end
                1: begin
                    // around the +-pi/2 fold of the rotation start
                    row.angle = 16'sd16382 + 16'($urandom_range(0, 4));
                    if ($urandom_range(0, 1)) begin
                        row.angle = -row.angle;
                    end
                end
                2: begin
                    row.x   = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    row.y   = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    row.mag = 15'h7FFF;
                    row.angle = 16'($urandom_range(0, 3) << 14);
                end
                default: ;
            endcase
            send_request(row);
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                source_idle($urandom_range(1, 6));
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("cartesian_polar_conversion regression: pass");
        end else begin
            $display("cartesian_polar_conversion regression: fail");
        end
        $finish;
    end

endmodule
